// ===== rtl/solar_to_lunar_date_macros.svh =====
// Assertion macros shared by the date converter.
// Both sample on the rising edge of clock; the first one is masked while reset is high.
`ifndef SOLAR_TO_LUNAR_DATE_MACROS_SVH
`define SOLAR_TO_LUNAR_DATE_MACROS_SVH

`define STLD_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`define STLD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/stld_pkg.sv =====
`timescale 1ns / 1ps

package stld_pkg;

   localparam int ROM_DEPTH_DEF = 256;
   localparam int BASE_YEAR_DEF = 1997;

   localparam int YEAR_W  = 12;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int NY_W    = YEAR_W + MONTH_W + DAY_W;
   localparam int MON_W   = 17;
   localparam int LEAP_W  = 4;
   localparam int NUM_W   = 16;
   localparam int DOY_W   = 9;
   localparam int SUM_W   = 9;

   localparam int ROM_ENTRIES = 204;
   localparam int ROM_ADDR_W  = $clog2(ROM_ENTRIES);
   localparam int ROM_IDX_W   = 10;

   localparam int MONTH_SLOTS   = 13;
   localparam int SHORT_MONTH   = 29;
   localparam int DAYS_PER_YEAR = 365;
   localparam int MONTHS_PER_YR = 12;
   localparam int MM_JANUARY    = 10;
   localparam int RECIP_100     = 5243;
   localparam int RECIP_SHIFT   = 19;

   typedef struct packed {
      logic [NUM_W-1:0]  p365;
      logic [9:0]        q4;
      logic [5:0]        c100;
      logic [3:0]        c400;
      logic [DOY_W-1:0]  doy;
   } day_terms_type;

   // Bits 12..0: months 1..13, set means 30 days. Bits 16..13: leap month number.
   localparam logic [31:0] MON_ROM [ROM_ENTRIES] = '{
      32'h00000000,
      32'h0000B26D, 32'h0000125C, 32'h0000192C, 32'h00009A95, 32'h00001A94, 32'h00001B4A,
      32'h00004B55, 32'h00000AD4, 32'h0000F55B,
      32'h000004BA, 32'h0000125A, 32'h0000B92B, 32'h0000152A, 32'h00001694, 32'h000096AA,
      32'h000015AA, 32'h00012AB5, 32'h00000974,
      32'h000014B6, 32'h0000CA57, 32'h00000A56, 32'h00001526, 32'h00008E95, 32'h00000D54,
      32'h000015AA, 32'h000049B5, 32'h0000096C,
      32'h0000D4AE, 32'h0000149C, 32'h00001A4C, 32'h0000BD26, 32'h00001AA6, 32'h00000B54,
      32'h00006D6A, 32'h000012DA, 32'h0001695D,
      32'h0000095A, 32'h0000149A, 32'h0000DA4B, 32'h00001A4A, 32'h00001AA4, 32'h0000BB54,
      32'h000016B4, 32'h00000ADA, 32'h0000495B,
      32'h00000936, 32'h0000F497, 32'h00001496, 32'h0000154A, 32'h0000B6A5, 32'h00000DA4,
      32'h000015B4, 32'h00006AB6, 32'h0000126E,
      32'h0001092F, 32'h0000092E, 32'h00000C96, 32'h0000CD4A, 32'h00001D4A, 32'h00000D64,
      32'h0000956C, 32'h0000155C, 32'h0000125C,
      32'h0000792E, 32'h0000192C, 32'h0000FA95, 32'h00001A94, 32'h00001B4A, 32'h0000AB55,
      32'h00000AD4, 32'h000014DA, 32'h00008A5D,
      32'h00000A5A, 32'h0001152B, 32'h0000152A, 32'h00001694, 32'h0000D6AA, 32'h000015AA,
      32'h00000AB4, 32'h000094BA, 32'h000014B6,
      32'h00000A56, 32'h00007527, 32'h00000D26, 32'h0000EE53, 32'h00000D54, 32'h000015AA,
      32'h0000A9B5, 32'h0000096C, 32'h000014AE,
      32'h00008A4E, 32'h00001A4C, 32'h00011D26, 32'h00001AA4, 32'h00001B54, 32'h0000CD6A,
      32'h00000ADA, 32'h0000095C, 32'h0000949D,
      32'h0000149A, 32'h00001A2A, 32'h00005B25, 32'h00001AA4, 32'h0000FB52, 32'h000016B4,
      32'h00000ABA, 32'h0000A95B, 32'h00000936,
      32'h00001496, 32'h00009A4B, 32'h0000154A, 32'h000136A5, 32'h00000DA4, 32'h000015AC,
      32'h0000CAB6, 32'h0000126E, 32'h0000092E,
      32'h00008C97, 32'h00000A96, 32'h00000D4A, 32'h00006DA5, 32'h00000D54, 32'h0000F56A,
      32'h0000155A, 32'h00000A5C, 32'h0000B92E,
      32'h0000152C, 32'h00001A94, 32'h00009D4A, 32'h00001B2A, 32'h00016B55, 32'h00000AD4,
      32'h000014DA, 32'h0000CA5D, 32'h00000A5A,
      32'h0000151A, 32'h0000BA95, 32'h00001654, 32'h000016AA, 32'h00004AD5, 32'h00000AB4,
      32'h0000F4BA, 32'h000014B6, 32'h00000A56,
      32'h0000B517, 32'h00000D16, 32'h00000E52, 32'h000096AA, 32'h00000D6A, 32'h000165B5,
      32'h0000096C, 32'h000014AE, 32'h0000CA2E,
      32'h00001A2C, 32'h00001D16, 32'h0000AD52, 32'h00001B52, 32'h00000B6A, 32'h0000656D,
      32'h0000055C, 32'h0000F45D, 32'h0000145A,
      32'h00001A2A, 32'h0000DA95, 32'h000016A4, 32'h00001AD2, 32'h00008B5A, 32'h00000AB6,
      32'h0001455B, 32'h000008B6, 32'h00001456,
      32'h0000D52B, 32'h0000152A, 32'h00001694, 32'h0000B6AA, 32'h000015AA, 32'h00000AB6,
      32'h000064B7, 32'h000008AE, 32'h0000EC57,
      32'h00000A56, 32'h00000D2A, 32'h0000CD95, 32'h00000B54, 32'h0000156A, 32'h00008A6D,
      32'h0000095C, 32'h000014AE, 32'h00004A56,
      32'h00001A54, 32'h0000DD2A, 32'h00001AAA, 32'h00000B54, 32'h0000B56A, 32'h000014DA,
      32'h0000095C, 32'h000074AB, 32'h0000149A,
      32'h0000FA4B, 32'h00001652, 32'h000016AA, 32'h0000CAD5, 32'h000005B4
   };

   // Gregorian date of each lunar new year, packed as year, month, day.
   localparam logic [31:0] NY_ROM [ROM_ENTRIES] = '{
      32'h00000000,
      32'h000F9C3C, 32'h000F9E50, 32'h000FA045, 32'h000FA238, 32'h000FA44C, 32'h000FA641,
      32'h000FA836, 32'h000FAA49, 32'h000FAC3D,
      32'h000FAE52, 32'h000FB047, 32'h000FB23A, 32'h000FB44E, 32'h000FB643, 32'h000FB837,
      32'h000FBA4A, 32'h000FBC3F, 32'h000FBE53,
      32'h000FC048, 32'h000FC23C, 32'h000FC450, 32'h000FC645, 32'h000FC839, 32'h000FCA4C,
      32'h000FCC41, 32'h000FCE36, 32'h000FD04A,
      32'h000FD23D, 32'h000FD451, 32'h000FD646, 32'h000FD83A, 32'h000FDA4D, 32'h000FDC43,
      32'h000FDE37, 32'h000FE04B, 32'h000FE23F,
      32'h000FE453, 32'h000FE648, 32'h000FE83C, 32'h000FEA4F, 32'h000FEC44, 32'h000FEE38,
      32'h000FF04C, 32'h000FF241, 32'h000FF436,
      32'h000FF64A, 32'h000FF83E, 32'h000FFA51, 32'h000FFC46, 32'h000FFE3A, 32'h0010004E,
      32'h00100242, 32'h00100437, 32'h0010064B,
      32'h00100841, 32'h00100A53, 32'h00100C48, 32'h00100E3C, 32'h0010104F, 32'h00101244,
      32'h00101438, 32'h0010164C, 32'h00101842,
      32'h00101A35, 32'h00101C49, 32'h00101E3D, 32'h00102051, 32'h00102245, 32'h0010243A,
      32'h0010264E, 32'h00102843, 32'h00102A37,
      32'h00102C4B, 32'h00102E3F, 32'h00103053, 32'h00103247, 32'h0010343B, 32'h0010364F,
      32'h00103845, 32'h00103A38, 32'h00103C4C,
      32'h00103E42, 32'h00104036, 32'h00104249, 32'h0010443D, 32'h00104651, 32'h00104846,
      32'h00104A3A, 32'h00104C4E, 32'h00104E43,
      32'h00105038, 32'h0010524A, 32'h0010543E, 32'h00105652, 32'h00105847, 32'h00105A3B,
      32'h00105C4F, 32'h00105E45, 32'h00106039,
      32'h0010624C, 32'h00106441, 32'h00106635, 32'h00106849, 32'h00106A3D, 32'h00106C51,
      32'h00106E47, 32'h0010703C, 32'h0010724F,
      32'h00107444, 32'h00107638, 32'h0010784C, 32'h00107A3F, 32'h00107C53, 32'h00107E48,
      32'h0010803D, 32'h00108250, 32'h00108446,
      32'h0010863A, 32'h0010884E, 32'h00108A42, 32'h00108C36, 32'h00108E4A, 32'h0010903E,
      32'h00109251, 32'h00109447, 32'h0010963B,
      32'h0010984F, 32'h00109A43, 32'h00109C37, 32'h00109E4B, 32'h0010A041, 32'h0010A253,
      32'h0010A448, 32'h0010A63D, 32'h0010A851,
      32'h0010AA45, 32'h0010AC39, 32'h0010AE4D, 32'h0010B042, 32'h0010B236, 32'h0010B44A,
      32'h0010B63E, 32'h0010B852, 32'h0010BA47,
      32'h0010BC3B, 32'h0010BE4F, 32'h0010C044, 32'h0010C237, 32'h0010C44B, 32'h0010C641,
      32'h0010C854, 32'h0010CA48, 32'h0010CC3D,
      32'h0010CE50, 32'h0010D045, 32'h0010D239, 32'h0010D44C, 32'h0010D642, 32'h0010D837,
      32'h0010DA4A, 32'h0010DC3E, 32'h0010DE52,
      32'h0010E047, 32'h0010E23A, 32'h0010E44E, 32'h0010E643, 32'h0010E838, 32'h0010EA4B,
      32'h0010EC41, 32'h0010EE54, 32'h0010F049,
      32'h0010F23C, 32'h0010F450, 32'h0010F645, 32'h0010F839, 32'h0010FA4C, 32'h0010FC42,
      32'h0010FE37, 32'h0011004B, 32'h0011023E,
      32'h00110452, 32'h00110647, 32'h0011083B, 32'h00110A4E, 32'h00110C43, 32'h00110E38,
      32'h0011104C, 32'h0011123F, 32'h00111435,
      32'h00111648, 32'h0011183C, 32'h00111A4F, 32'h00111C45, 32'h00111E39, 32'h0011204D,
      32'h00112242, 32'h00112436, 32'h0011264A,
      32'h0011283E, 32'h00112A51, 32'h00112C46, 32'h00112E3B, 32'h0011304F
   };

   function automatic logic [NY_W-1:0] ny_rom_read(input logic [ROM_IDX_W-1:0] addr);
      logic [31:0] word;
      word = '0;
      if (addr < ROM_IDX_W'(ROM_ENTRIES)) begin
         word = NY_ROM[addr[ROM_ADDR_W-1:0]];
      end
      return word[NY_W-1:0];
   endfunction

   function automatic logic [MON_W-1:0] mon_rom_read(input logic [ROM_IDX_W-1:0] addr);
      logic [31:0] word;
      word = '0;
      if (addr < ROM_IDX_W'(ROM_ENTRIES)) begin
         word = MON_ROM[addr[ROM_ADDR_W-1:0]];
      end
      return word[MON_W-1:0];
   endfunction

   // Month index of a year that starts in March: March is 0, February is 11.
   function automatic logic [MONTH_W-1:0] march_month(input logic [MONTH_W-1:0] m);
      logic [MONTH_W-1:0] mm;
      if (m >= MONTH_W'(3)) begin
         mm = m - MONTH_W'(3);
      end else begin
         mm = m + MONTH_W'(MONTHS_PER_YR - 3);
      end
      return mm;
   endfunction

   // Days from March 1 to the first of the given March-based month.
   function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] mm);
      logic [DOY_W-1:0] d;
      case (mm)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd31;
         4'd2:    d = 9'd61;
         4'd3:    d = 9'd92;
         4'd4:    d = 9'd122;
         4'd5:    d = 9'd153;
         4'd6:    d = 9'd184;
         4'd7:    d = 9'd214;
         4'd8:    d = 9'd245;
         4'd9:    d = 9'd275;
         4'd10:   d = 9'd306;
         4'd11:   d = 9'd337;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

   // Products of the day count; the divides by 100 and 400 use a reciprocal that is
   // exact for any 12-bit year.
   function automatic day_terms_type day_terms(input logic [YEAR_W-1:0] yy,
                                               input logic [DOY_W-1:0] doy);
      day_terms_type     t;
      logic [20:0]       p;
      logic [24:0]       c1;
      logic [22:0]       c2;
      logic [9:0]        q;
      q      = yy[YEAR_W-1:2];
      p      = 21'(yy) * 21'(DAYS_PER_YEAR);
      c1     = 25'(yy) * 25'(RECIP_100);
      c2     = 23'(q) * 23'(RECIP_100);
      t.p365 = p[NUM_W-1:0];
      t.q4   = q;
      t.c100 = c1[RECIP_SHIFT +: 6];
      t.c400 = c2[RECIP_SHIFT +: 4];
      t.doy  = doy;
      return t;
   endfunction

   function automatic logic [NUM_W-1:0] day_sum(input day_terms_type t);
      return t.p365 + NUM_W'(t.q4) - NUM_W'(t.c100) + NUM_W'(t.c400) + NUM_W'(t.doy);
   endfunction

endpackage

// ===== rtl/solar_to_lunar_date.sv =====
// Gregorian to Chinese lunar date converter, seven-stage pipeline around two table ROMs.
// rsp_strobe is the accept strobe carried along a shift register beside the data stages.
// Throughput: one item per cycle; busy is always low and the receiver cannot stall.
// The ROM read at the new-year index and the one before it sets the first stage.
// Reset (synchronous, active high) empties the pipeline; no result follows it.
`timescale 1ns / 1ps
`include "solar_to_lunar_date_macros.svh"

module solar_to_lunar_date
   import stld_pkg::*;
#(
   parameter int ROM_DEPTH = ROM_DEPTH_DEF,
   parameter int BASE_YEAR = BASE_YEAR_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [YEAR_W-1:0]  req_greg_year,
   input  logic [MONTH_W-1:0] req_greg_month,
   input  logic [DAY_W-1:0]   req_greg_day,
   output logic               rsp_strobe,
   output logic               rsp_valid_res,
   output logic [YEAR_W-1:0]  rsp_lunar_year,
   output logic [MONTH_W-1:0] rsp_lunar_month,
   output logic [DAY_W-1:0]   rsp_lunar_day,
   output logic               rsp_leap_flag
);

   localparam int IDX_W  = $clog2(ROM_DEPTH);
   localparam int STAGES = 7;
   localparam logic [YEAR_W-1:0] YEAR_BASE = YEAR_W'(BASE_YEAR);
   localparam logic [YEAR_W-1:0] YEAR_LO   = YEAR_W'(BASE_YEAR + 3);
   localparam logic [YEAR_W-1:0] YEAR_HI   = YEAR_W'(BASE_YEAR + 202);

   logic               accept;
   logic [STAGES-1:0]  stb_ff, stb_in;

   // ---------------- stage 1: range check, ROM reads ----------------
   logic               in_ok_in;
   logic [YEAR_W-1:0]  year_off_in;
   logic [IDX_W-1:0]   idx_cur_in, idx_prev_in;
   logic [MONTH_W-1:0] mm_in;
   logic [YEAR_W-1:0]  yy_in;
   logic [DOY_W-1:0]   doy_in;

   logic               s1_ok_ff;
   logic [NY_W-1:0]    s1_packed_ff;
   logic [IDX_W-1:0]   s1_idx_ff;
   logic [YEAR_W-1:0]  s1_yy_ff;
   logic [DOY_W-1:0]   s1_doy_ff;
   logic [NY_W-1:0]    ny_cur_ff, ny_prev_ff;
   logic [MON_W-1:0]   mon_cur_ff, mon_prev_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign stb_in = {stb_ff[STAGES-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         stb_ff <= '0;
      end else begin
         stb_ff <= stb_in;
      end
   end

   always_comb begin
      in_ok_in = (req_greg_month >= MONTH_W'(1)) && (req_greg_month <= MONTH_W'(MONTHS_PER_YR))
               && (req_greg_day != '0)
               && (req_greg_year >= YEAR_LO) && (req_greg_year <= YEAR_HI);
      year_off_in = req_greg_year - YEAR_BASE;
      idx_cur_in  = year_off_in[IDX_W-1:0];
      idx_prev_in = idx_cur_in - IDX_W'(1);
      mm_in       = march_month(req_greg_month);
      yy_in       = (mm_in >= MONTH_W'(MM_JANUARY)) ? req_greg_year - YEAR_W'(1) : req_greg_year;
      doy_in      = days_before(mm_in) + DOY_W'(req_greg_day) - DOY_W'(1);
   end

   always_ff @(posedge clock) begin
      s1_ok_ff     <= in_ok_in;
      s1_packed_ff <= {req_greg_year, req_greg_month, req_greg_day};
      s1_idx_ff    <= idx_cur_in;
      s1_yy_ff     <= yy_in;
      s1_doy_ff    <= doy_in;
      ny_cur_ff    <= ny_rom_read(ROM_IDX_W'(idx_cur_in));
      ny_prev_ff   <= ny_rom_read(ROM_IDX_W'(idx_prev_in));
      mon_cur_ff   <= mon_rom_read(ROM_IDX_W'(idx_cur_in));
      mon_prev_ff  <= mon_rom_read(ROM_IDX_W'(idx_prev_in));
   end

   // ---------------- stage 2: pick the lunar year ----------------
   logic               take_prev_in;
   logic [NY_W-1:0]    ny_sel_in;
   logic [MONTH_W-1:0] ny_mm_in;
   logic [YEAR_W-1:0]  ny_yy_in;
   logic [DOY_W-1:0]   ny_doy_in;

   logic               s2_ok_ff;
   logic [IDX_W-1:0]   s2_idx_ff;
   logic [MON_W-1:0]   s2_mon_ff;
   logic [YEAR_W-1:0]  s2_in_yy_ff, s2_ny_yy_ff;
   logic [DOY_W-1:0]   s2_in_doy_ff, s2_ny_doy_ff;

   always_comb begin
      // A date before this year's new year belongs to the previous lunar year.
      take_prev_in = ny_cur_ff > s1_packed_ff;
      ny_sel_in    = take_prev_in ? ny_prev_ff : ny_cur_ff;
      ny_mm_in     = march_month(ny_sel_in[DAY_W +: MONTH_W]);
      ny_yy_in     = ny_sel_in[NY_W-1 -: YEAR_W];
      if (ny_mm_in >= MONTH_W'(MM_JANUARY)) begin
         ny_yy_in = ny_yy_in - YEAR_W'(1);
      end
      ny_doy_in = days_before(ny_mm_in) + DOY_W'(ny_sel_in[DAY_W-1:0]) - DOY_W'(1);
   end

   always_ff @(posedge clock) begin
      s2_ok_ff     <= s1_ok_ff;
      s2_idx_ff    <= take_prev_in ? s1_idx_ff - IDX_W'(1) : s1_idx_ff;
      s2_mon_ff    <= take_prev_in ? mon_prev_ff : mon_cur_ff;
      s2_in_yy_ff  <= s1_yy_ff;
      s2_in_doy_ff <= s1_doy_ff;
      s2_ny_yy_ff  <= ny_yy_in;
      s2_ny_doy_ff <= ny_doy_in;
   end

   // ---------------- stage 3: day count products ----------------
   logic               s3_ok_ff;
   logic [IDX_W-1:0]   s3_idx_ff;
   logic [MON_W-1:0]   s3_mon_ff;
   day_terms_type      s3_in_terms_ff, s3_ny_terms_ff;

   always_ff @(posedge clock) begin
      s3_ok_ff       <= s2_ok_ff;
      s3_idx_ff      <= s2_idx_ff;
      s3_mon_ff      <= s2_mon_ff;
      s3_in_terms_ff <= day_terms(s2_in_yy_ff, s2_in_doy_ff);
      s3_ny_terms_ff <= day_terms(s2_ny_yy_ff, s2_ny_doy_ff);
   end

   // ---------------- stage 4: day numbers ----------------
   logic               s4_ok_ff;
   logic [IDX_W-1:0]   s4_idx_ff;
   logic [MON_W-1:0]   s4_mon_ff;
   logic [NUM_W-1:0]   s4_in_num_ff, s4_ny_num_ff;

   always_ff @(posedge clock) begin
      s4_ok_ff     <= s3_ok_ff;
      s4_idx_ff    <= s3_idx_ff;
      s4_mon_ff    <= s3_mon_ff;
      s4_in_num_ff <= day_sum(s3_in_terms_ff);
      s4_ny_num_ff <= day_sum(s3_ny_terms_ff);
   end

   // ---------------- stage 5: day offset, month end sums ----------------
   logic [NUM_W-1:0]   off_in;
   logic [SUM_W-1:0]   sum_in [MONTH_SLOTS];

   logic               s5_ok_ff;
   logic [IDX_W-1:0]   s5_idx_ff;
   logic [LEAP_W-1:0]  s5_leap_ff;
   logic [NUM_W-1:0]   s5_off_ff;
   logic [SUM_W-1:0]   s5_sum_ff [MONTH_SLOTS];

   always_comb begin
      off_in = s4_in_num_ff - s4_ny_num_ff + NUM_W'(1);
      // Entry k is the day count of the first k+1 months; bit 12 is the first month.
      for (int k = 0; k < MONTH_SLOTS; k++) begin
         sum_in[k] = SUM_W'(SHORT_MONTH * (k + 1))
                   + SUM_W'($countones(s4_mon_ff[MONTH_SLOTS-1:0]
                                       & ~(13'h1FFF >> (k + 1))));
      end
   end

   always_ff @(posedge clock) begin
      s5_ok_ff   <= s4_ok_ff;
      s5_idx_ff  <= s4_idx_ff;
      s5_leap_ff <= s4_mon_ff[MON_W-1 -: LEAP_W];
      s5_off_ff  <= off_in;
      s5_sum_ff  <= sum_in;
   end

   // ---------------- stage 6: month search ----------------
   logic [MONTH_SLOTS:0] gt_in;
   logic [MONTH_W-1:0]   cnt_in;
   logic [SUM_W-1:0]     base_in;

   logic               s6_ok_ff;
   logic [IDX_W-1:0]   s6_idx_ff;
   logic [LEAP_W-1:0]  s6_leap_ff;
   logic [MONTH_W-1:0] s6_cnt_ff;
   logic [SUM_W-1:0]   s6_base_ff;
   logic [DAY_W-1:0]   s6_off_ff;

   always_comb begin
      gt_in = '0;
      for (int k = 0; k < MONTH_SLOTS; k++) begin
         gt_in[k] = s5_off_ff > NUM_W'(s5_sum_ff[k]);
      end
      cnt_in = MONTH_W'($countones(gt_in));
      // The month sums rise, so the passed months form a prefix; its last sum is peeled.
      base_in = '0;
      for (int k = 0; k < MONTH_SLOTS; k++) begin
         if (gt_in[k] && !gt_in[k+1]) begin
            base_in = base_in | s5_sum_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      s6_ok_ff   <= s5_ok_ff;
      s6_idx_ff  <= s5_idx_ff;
      s6_leap_ff <= s5_leap_ff;
      s6_cnt_ff  <= cnt_in;
      s6_base_ff <= base_in;
      s6_off_ff  <= s5_off_ff[DAY_W-1:0];
   end

   // ---------------- stage 7: leap fold, result register ----------------
   logic [MONTH_W-1:0] lm_in;
   logic [MONTH_W-1:0] month_out_in;
   logic               leap_out_in;

   logic               valid_res_ff;
   logic [YEAR_W-1:0]  lunar_year_ff;
   logic [MONTH_W-1:0] lunar_month_ff;
   logic [DAY_W-1:0]   lunar_day_ff;
   logic               leap_flag_ff;

   always_comb begin
      lm_in        = s6_cnt_ff + MONTH_W'(1);
      month_out_in = lm_in;
      leap_out_in  = 1'b0;
      // Months after the leap month shift down by one; the one right after it is the leap.
      if ((s6_leap_ff != '0) && (lm_in > s6_leap_ff)) begin
         leap_out_in  = (lm_in == s6_leap_ff + LEAP_W'(1));
         month_out_in = lm_in - MONTH_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      valid_res_ff   <= s6_ok_ff;
      lunar_year_ff  <= s6_ok_ff ? YEAR_BASE + YEAR_W'(s6_idx_ff) : '0;
      lunar_month_ff <= s6_ok_ff ? month_out_in : '0;
      lunar_day_ff   <= s6_ok_ff ? s6_off_ff - s6_base_ff[DAY_W-1:0] : '0;
      leap_flag_ff   <= s6_ok_ff && leap_out_in;
   end

   assign rsp_strobe      = stb_ff[STAGES-1];
   assign rsp_valid_res   = valid_res_ff;
   assign rsp_lunar_year  = lunar_year_ff;
   assign rsp_lunar_month = lunar_month_ff;
   assign rsp_lunar_day   = lunar_day_ff;
   assign rsp_leap_flag   = leap_flag_ff;

   // ---------------- assertions ----------------
   logic rsp_valid_out;
   logic rsp_reject;
   logic rsp_year_ok;
   logic rsp_zeroed;

   assign rsp_valid_out = rsp_strobe && rsp_valid_res;
   assign rsp_reject    = rsp_strobe && !rsp_valid_res;
   assign rsp_year_ok   = (rsp_lunar_year >= YEAR_W'(BASE_YEAR + 2))
                        && (rsp_lunar_year <= YEAR_HI);
   assign rsp_zeroed    = (rsp_lunar_year == '0) && (rsp_lunar_month == '0)
                        && (rsp_lunar_day == '0) && !rsp_leap_flag;

   `STLD_ASSERT_RST(a_latency, accept |-> ##7 rsp_strobe, "result strobe missing after item")
   `STLD_ASSERT(a_reset_flush, reset |=> !rsp_strobe, "result strobe right after reset")
   `STLD_ASSERT_RST(a_year_range, rsp_valid_out |-> rsp_year_ok, "lunar year out of range")
   `STLD_ASSERT_RST(a_invalid_zero, rsp_reject |-> rsp_zeroed, "rejected item has nonzero fields")

endmodule
